[rtl/core/rrsg_pkg.sv]
// Shared types, constants and the square root step for the rounded rectangle span generator.
package rrsg_pkg;

   localparam int COORD_BITS   = 12;
   localparam int RAD_BITS     = COORD_BITS - 1;
   localparam int SQ_BITS      = 2 * RAD_BITS;
   localparam int EXT_BITS     = COORD_BITS + 2;
   localparam int DIM_BITS     = 13;
   localparam int COLOUR_BITS  = 8;
   localparam int SQRT_STAGES  = RAD_BITS;
   localparam int REM_BITS     = RAD_BITS + 3;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int FRONT_STAGES = 2;
   // front stages, queue slot, back input stage, root stages, output register
   localparam int RSP_LATENCY  = FRONT_STAGES + 3 + SQRT_STAGES;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = DIM_BITS'(320);
   localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = DIM_BITS'(256);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   // one classified row, handed from front to back
   typedef struct packed {
      logic                          ok;
      logic [SQ_BITS-1:0]            n;
      logic signed [COORD_BITS:0]    xa;
      logic signed [COORD_BITS:0]    xb;
      logic [COLOUR_BITS-1:0]        colour;
   } span_job_type;

   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [RAD_BITS-1:0] root;
   } sqrt_state_type;

   // one digit of the restoring square root: brings in the next two radicand bits
   function automatic sqrt_state_type sqrt_step(sqrt_state_type cur, logic [1:0] pair);
      logic [REM_BITS-1:0] shifted;
      logic [REM_BITS-1:0] trial;
      sqrt_state_type      nxt;
      shifted = {cur.rem[REM_BITS-3:0], pair};
      trial   = REM_BITS'({cur.root, 2'b01});
      if (shifted >= trial) begin
         nxt.rem  = shifted - trial;
         nxt.root = {cur.root[RAD_BITS-2:0], 1'b1};
      end else begin
         nxt.rem  = shifted;
         nxt.root = {cur.root[RAD_BITS-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

[rtl/core/rounded_rect_span_gen.sv]
// Rounded rectangle span generator: one clipped fill span per requested row.
// A request is taken on any clock where start is high and busy is low, one per clock with no
// gaps; each request yields exactly one result on rsp_strobe, in request order. Each request
// passes through the classify/square front end, the queue, a back end input stage, the 11-stage
// integer square root pipeline (one root bit per stage) and an output register. The result side
// has no backpressure; the back end drains the queue every clock, so busy stays low in operation.
// Screen size registers are written through the csr_ port, which is always ready; write them
// only while no request is in flight.
module rounded_rect_span_gen
   import rrsg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_BITS-1:0]  req_left,
   input  logic signed [COORD_BITS-1:0]  req_top,
   input  logic signed [COORD_BITS-1:0]  req_right,
   input  logic signed [COORD_BITS-1:0]  req_bottom,
   input  logic [RAD_BITS-1:0]           req_radius,
   input  logic [COLOUR_BITS-1:0]        req_colour,
   input  logic signed [COORD_BITS-1:0]  req_row,
   output logic                          rsp_strobe,
   output logic                          rsp_span_valid,
   output logic [COORD_BITS-1:0]         rsp_span_start,
   output logic [COORD_BITS-1:0]         rsp_span_end,
   output logic [COLOUR_BITS-1:0]        rsp_span_colour,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [DIM_BITS-1:0]           csr_data
);

   logic [DIM_BITS-1:0] screen_width_ff, screen_width_in;
   logic [DIM_BITS-1:0] screen_height_ff, screen_height_in;
   logic                accept;
   logic                front_valid, queue_valid, queue_almost_full;
   span_job_type        front_job, queue_job;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = queue_almost_full;

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_data;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   rrsg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .left          (req_left),
      .top           (req_top),
      .right         (req_right),
      .bottom        (req_bottom),
      .radius        (req_radius),
      .colour        (req_colour),
      .row           (req_row),
      .screen_height (screen_height_ff),
      .job_valid     (front_valid),
      .job           (front_job)
   );

   rrsg_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (front_valid),
      .push_data   (front_job),
      .pop_valid   (queue_valid),
      .pop_data    (queue_job),
      .almost_full (queue_almost_full)
   );

   rrsg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (queue_valid),
      .job          (queue_job),
      .screen_width (screen_width_ff),
      .rsp_strobe   (rsp_strobe),
      .span_valid   (rsp_span_valid),
      .span_start   (rsp_span_start),
      .span_end     (rsp_span_end),
      .span_colour  (rsp_span_colour)
   );

   // every accepted request produces a result on rsp_strobe
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##RSP_LATENCY rsp_strobe)
      else $error("request did not produce a result on time");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without a matching request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_span_valid |-> rsp_span_start <= rsp_span_end)
      else $error("span start beyond span end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_span_valid |->
         rsp_span_start == '0 && rsp_span_end == '0 && rsp_span_colour == '0)
      else $error("empty span carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("queue backed up although the back end drains every clock");

endmodule

[rtl/core/rrsg_front.sv]
// Front end: classifies a request, finds the corner depth and forms r*r - k*k.
module rrsg_front
   import rrsg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [COORD_BITS-1:0]  left,
   input  logic signed [COORD_BITS-1:0]  top,
   input  logic signed [COORD_BITS-1:0]  right,
   input  logic signed [COORD_BITS-1:0]  bottom,
   input  logic [RAD_BITS-1:0]           radius,
   input  logic [COLOUR_BITS-1:0]        colour,
   input  logic signed [COORD_BITS-1:0]  row,
   input  logic [DIM_BITS-1:0]           screen_height,
   output logic                          job_valid,
   output span_job_type                  job
);

   logic signed [EXT_BITS-1:0] x0_e, y0_e, x1_e, y1_e, r_e, row_e, sh_e;
   logic signed [EXT_BITS-1:0] dx, dy, r2, depth_a, depth_b, depth_m;
   logic                       size_ok, in_box, on_screen;
   logic [RAD_BITS-1:0]        k_in;
   logic signed [COORD_BITS:0] xa_in, xb_in;

   logic                       s1_valid_ff;
   logic                       s1_ok_ff;
   logic [RAD_BITS-1:0]        s1_r_ff;
   logic [RAD_BITS-1:0]        s1_k_ff;
   logic signed [COORD_BITS:0] s1_xa_ff, s1_xb_ff;
   logic [COLOUR_BITS-1:0]     s1_colour_ff;

   logic                       s2_valid_ff;
   logic                       s2_ok_ff;
   logic [SQ_BITS-1:0]         s2_rr_ff, s2_kk_ff;
   logic signed [COORD_BITS:0] s2_xa_ff, s2_xb_ff;
   logic [COLOUR_BITS-1:0]     s2_colour_ff;

   always_comb begin
      x0_e    = EXT_BITS'(left);
      y0_e    = EXT_BITS'(top);
      x1_e    = EXT_BITS'(right);
      y1_e    = EXT_BITS'(bottom);
      row_e   = EXT_BITS'(row);
      r_e     = $signed(EXT_BITS'(radius));
      sh_e    = $signed(EXT_BITS'(screen_height));
      dx      = x1_e - x0_e;
      dy      = y1_e - y0_e;
      r2      = r_e + r_e;
      size_ok = (dx >= r2) && (dy >= r2);
      in_box  = (row_e >= y0_e) && (row_e <= y1_e);
      on_screen = (row_e >= 0) && (row_e < sh_e);
      depth_a = y0_e + r_e - row_e;
      depth_b = row_e - y1_e + r_e;
      depth_m = (depth_a > depth_b) ? depth_a : depth_b;
      if (depth_m < 0) begin
         k_in = '0;
      end else if (depth_m > r_e) begin
         k_in = radius;
      end else begin
         k_in = depth_m[RAD_BITS-1:0];
      end
      xa_in = (COORD_BITS+1)'(x0_e + r_e);
      xb_in = (COORD_BITS+1)'(x1_e - r_e);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff     <= size_ok && in_box && on_screen;
      s1_r_ff      <= radius;
      s1_k_ff      <= k_in;
      s1_xa_ff     <= xa_in;
      s1_xb_ff     <= xb_in;
      s1_colour_ff <= colour;

      s2_ok_ff     <= s1_ok_ff;
      s2_rr_ff     <= s1_r_ff * s1_r_ff;
      s2_kk_ff     <= s1_k_ff * s1_k_ff;
      s2_xa_ff     <= s1_xa_ff;
      s2_xb_ff     <= s1_xb_ff;
      s2_colour_ff <= s1_colour_ff;
   end

   // k never exceeds r, so the difference stays non-negative
   always_comb begin
      job_valid  = s2_valid_ff;
      job.ok     = s2_ok_ff;
      job.n      = s2_rr_ff - s2_kk_ff;
      job.xa     = s2_xa_ff;
      job.xb     = s2_xb_ff;
      job.colour = s2_colour_ff;
   end

endmodule

[rtl/core/rrsg_queue.sv]
// Short queue between front and back; the back drains one entry per clock.
module rrsg_queue
   import rrsg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  span_job_type  push_data,
   output logic          pop_valid,
   output span_job_type  pop_data,
   output logic          almost_full
);

   span_job_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   always_comb begin
      pop_valid   = (count_ff != '0);
      pop_data    = entries_ff[rd_ptr_ff];
      // leave room for what the front already has in flight
      almost_full = (count_ff >= (QPTR_BITS+1)'(QUEUE_DEPTH - FRONT_STAGES));
      wr_ptr_in   = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = pop_valid ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in    = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/rrsg_back.sv]
// Back end: pipelined integer square root, span placement and horizontal clipping.
module rrsg_back
   import rrsg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   input  span_job_type            job,
   input  logic [DIM_BITS-1:0]     screen_width,
   output logic                    rsp_strobe,
   output logic                    span_valid,
   output logic [COORD_BITS-1:0]   span_start,
   output logic [COORD_BITS-1:0]   span_end,
   output logic [COLOUR_BITS-1:0]  span_colour
);

   logic           valid_ff [SQRT_STAGES+1];
   span_job_type   job_ff   [SQRT_STAGES+1];
   span_job_type   job_in   [SQRT_STAGES+1];
   sqrt_state_type root_ff  [SQRT_STAGES+1];
   sqrt_state_type step_in  [SQRT_STAGES+1];

   logic signed [EXT_BITS-1:0] hw_e, xs, xs_c;
   logic signed [EXT_BITS:0]   xe, xe_c, sw_m1, xs_w;
   logic                       valid_in;
   logic [COORD_BITS-1:0]      start_in, end_in;
   logic [COLOUR_BITS-1:0]     colour_in;

   logic                       strobe_ff;
   logic                       span_valid_ff;
   logic [COORD_BITS-1:0]      span_start_ff, span_end_ff;
   logic [COLOUR_BITS-1:0]     span_colour_ff;

   // radicand shifts up two bits per stage so each stage reads the same top pair
   always_comb begin
      step_in[0] = '0;
      job_in[0]  = job;
      for (int s = 1; s <= SQRT_STAGES; s++) begin
         step_in[s]  = sqrt_step(root_ff[s-1], job_ff[s-1].n[SQ_BITS-1 -: 2]);
         job_in[s]   = job_ff[s-1];
         job_in[s].n = {job_ff[s-1].n[SQ_BITS-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= SQRT_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= job_valid;
         for (int s = 1; s <= SQRT_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= SQRT_STAGES; s++) begin
         job_ff[s]  <= job_in[s];
         root_ff[s] <= step_in[s];
      end
   end

   always_comb begin
      hw_e  = $signed(EXT_BITS'(root_ff[SQRT_STAGES].root));
      xs    = EXT_BITS'(job_ff[SQRT_STAGES].xa) - hw_e;
      xe    = (EXT_BITS+1)'(EXT_BITS'(job_ff[SQRT_STAGES].xb) + hw_e);
      sw_m1 = $signed({2'b00, screen_width}) - (EXT_BITS+1)'(1);
      xs_c  = (xs < 0) ? '0 : xs;
      xe_c  = (xe > sw_m1) ? sw_m1 : xe;
      xs_w  = (EXT_BITS+1)'(xs_c);
      valid_in  = job_ff[SQRT_STAGES].ok && (xs_w <= xe_c);
      start_in  = valid_in ? xs_c[COORD_BITS-1:0] : '0;
      end_in    = valid_in ? xe_c[COORD_BITS-1:0] : '0;
      colour_in = valid_in ? job_ff[SQRT_STAGES].colour : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid_ff[SQRT_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      span_valid_ff  <= valid_in;
      span_start_ff  <= start_in;
      span_end_ff    <= end_in;
      span_colour_ff <= colour_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign span_valid  = span_valid_ff;
   assign span_start  = span_start_ff;
   assign span_end    = span_end_ff;
   assign span_colour = span_colour_ff;

endmodule
